[design/sfm_pkg.sv]
// Shared constants and types for the substring first-match search block.
package sfm_pkg;

  // Default sizing
  localparam int MAX_PATTERN_DEF = 16;
  localparam int INDEX_BITS_DEF  = 16;

  // Fixed field widths
  localparam int BYTE_BITS        = 8;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 64;
  localparam int LENGTH_BITS      = 5;
  localparam int MATCH_START_BITS = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd2;

  // Per-byte control broadcast to every cell
  typedef struct packed {
    logic advance;  // byte taken while search still open
    logic clear;    // last byte of text taken: drop partial matches
  } cell_ctrl_t;

endpackage

[design/sfm_cell.sv]
// One pattern position: compares the text byte and extends the partial match.
module sfm_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  sfm_pkg::cell_ctrl_t            ctrl,
  input  logic                           active,
  input  logic                           prev_match,
  input  logic [sfm_pkg::BYTE_BITS-1:0]  text_byte,
  input  logic [sfm_pkg::BYTE_BITS-1:0]  pattern_byte,
  output logic                           match_next,
  output logic                           match
);

  // Match through this position if the previous position matched last byte
  assign match_next = prev_match & (text_byte == pattern_byte);

  // Partial-match bit, handed to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.advance) begin
      match <= active & match_next;
    end
  end

endmodule

[design/substring_first_match_core.sv]
// Top level of the streaming substring first-match search.
// A result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one text byte per cycle while the skid entry is empty; all cells compare
// in parallel in that cycle, and the start-index subtract sits in the same cycle.
// A two-entry output buffer keeps input flowing while a result waits.
// Reset (synchronous): clears partial matches, position, done flag and output buffer;
// pattern bytes reset to zero and pattern length to 1.
module substring_first_match_core #(
  parameter int MAX_PATTERN = sfm_pkg::MAX_PATTERN_DEF,
  parameter int INDEX_BITS  = sfm_pkg::INDEX_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // text input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sfm_pkg::BYTE_BITS-1:0]        text_byte,
  input  logic                                 end_of_text,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 found,
  output logic [sfm_pkg::MATCH_START_BITS-1:0] match_start,
  output logic                                 index_overflow,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sfm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sfm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int LEN_IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int POS_BITS     = INDEX_BITS + 1;
  localparam int START_W      = (INDEX_BITS > sfm_pkg::MATCH_START_BITS) ?
                                INDEX_BITS : sfm_pkg::MATCH_START_BITS;

  typedef struct packed {
    logic                                 found;
    logic [sfm_pkg::MATCH_START_BITS-1:0] match_start;
    logic                                 index_overflow;
  } result_t;

  // Configuration registers
  logic [sfm_pkg::CFG_DATA_BITS-1:0]   pattern_low;
  logic [sfm_pkg::CFG_DATA_BITS-1:0]   pattern_high;
  logic [LEN_IDX_BITS-1:0]             last_idx;
  logic [LEN_IDX_BITS-1:0]             last_idx_next;
  logic [sfm_pkg::LENGTH_BITS-1:0]     cfg_length;
  logic [2*sfm_pkg::CFG_DATA_BITS-1:0] pattern_all;

  // Text state
  logic [POS_BITS-1:0]    text_position;
  logic                   search_done;
  logic [MAX_PATTERN-1:0] cell_match;
  logic [MAX_PATTERN-1:0] cell_next;
  sfm_pkg::cell_ctrl_t    ctrl;

  // Result path
  logic                   accept;
  logic                   hit;
  logic                   ovf;
  logic [POS_BITS-1:0]    last_idx_wide;
  logic [POS_BITS-1:0]    start_diff;
  logic [INDEX_BITS-1:0]  start_idx;
  logic [START_W-1:0]     start_wide;
  logic                   res_valid;
  result_t                res;
  result_t                out_res;
  result_t                skid_res;
  logic                   skid_valid;

  assign cfg_ready   = 1'b1;
  assign pattern_all = {pattern_high, pattern_low};
  assign cfg_length  = cfg_data[sfm_pkg::LENGTH_BITS-1:0];

  // Length written maps to index of last pattern byte, clamped to the cell row
  always_comb begin
    if (cfg_length == '0) begin
      last_idx_next = '0;
    end else if (cfg_length > sfm_pkg::LENGTH_BITS'(MAX_PATTERN)) begin
      last_idx_next = LEN_IDX_BITS'(MAX_PATTERN - 1);
    end else begin
      last_idx_next = LEN_IDX_BITS'(cfg_length - 5'd1);
    end
  end

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      last_idx     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfm_pkg::REG_PATTERN_LOW:    pattern_low  <= cfg_data;
        sfm_pkg::REG_PATTERN_HIGH:   pattern_high <= cfg_data;
        sfm_pkg::REG_PATTERN_LENGTH: last_idx     <= last_idx_next;
        default: ;
      endcase
    end
  end

  // Byte handshake and cell control
  assign in_ready     = !skid_valid;
  assign accept       = in_valid && in_ready;
  assign ctrl.advance = accept && !search_done;
  assign ctrl.clear   = accept && end_of_text;

  // Row of compare cells
  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic prev;
      if (k == 0) begin : g_first
        assign prev = 1'b1;
      end else begin : g_rest
        assign prev = cell_match[k-1];
      end
      sfm_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .active       (LEN_IDX_BITS'(k) <= last_idx),
        .prev_match   (prev),
        .text_byte    (text_byte),
        .pattern_byte (pattern_all[sfm_pkg::BYTE_BITS*k +: sfm_pkg::BYTE_BITS]),
        .match_next   (cell_next[k]),
        .match        (cell_match[k])
      );
    end
  endgenerate

  // Full match and start index
  assign hit           = cell_next[last_idx];
  assign ovf           = text_position[INDEX_BITS];
  assign last_idx_wide = POS_BITS'(last_idx);
  assign start_diff    = text_position - last_idx_wide;

  always_comb begin
    if (ovf) begin
      start_idx = '1;
    end else if (text_position < last_idx_wide) begin
      start_idx = '0;
    end else begin
      start_idx = start_diff[INDEX_BITS-1:0];
    end
  end

  assign start_wide = START_W'(start_idx);

  assign res_valid          = ctrl.advance && (hit || end_of_text);
  assign res.found          = hit;
  assign res.match_start    = hit ? start_wide[sfm_pkg::MATCH_START_BITS-1:0] : '0;
  assign res.index_overflow = ovf;

  // Position counter and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
      search_done   <= 1'b0;
    end else if (ctrl.clear) begin
      text_position <= '0;
      search_done   <= 1'b0;
    end else if (ctrl.advance) begin
      if (!ovf) text_position <= text_position + POS_BITS'(1);
      if (hit) search_done <= 1'b1;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (res_valid) begin
        out_res <= res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (res_valid) begin
        out_valid <= 1'b1;
        out_res   <= res;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_res   <= res;
    end
  end

  assign found          = out_res.found;
  assign match_start    = out_res.match_start;
  assign index_overflow = out_res.index_overflow;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while output register is empty");

  a_done_after_hit: assert property (@(posedge clk) disable iff (rst)
    (ctrl.advance && hit && !end_of_text) |=> search_done)
    else $error("match reported but search not closed");

  a_position_saturates: assert property (@(posedge clk) disable iff (rst)
    (ctrl.advance && !end_of_text && ovf) |=> text_position[INDEX_BITS])
    else $error("text position left saturation without end of text");

  a_no_result_when_done: assert property (@(posedge clk) disable iff (rst)
    (accept && search_done && !skid_valid && out_valid && !out_ready) |=> !skid_valid)
    else $error("result queued for byte after a match");

endmodule
